FILE: src/rmq_pkg.sv
// Shared constants, types and helpers for the rotation matrix to quaternion block.
// Used by every module under src; depends on nothing.
package rmq_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    // A diagonal candidate is a sum of three entries.
    localparam int CAND_W     = DATA_WIDTH + 2;
    // The square-root radicand is (candidate + 1.0) << FRAC_BITS.
    localparam int RAD_W      = CAND_W + FRAC_BITS + 1;
    localparam int ROOT_W     = (RAD_W + 1) / 2;
    // An off-diagonal numerator is a sum of two entries.
    localparam int NUM_W      = DATA_WIDTH + 1;
    localparam int MAG_W      = NUM_W;
    localparam int DIVD_W     = MAG_W + FRAC_BITS;
    localparam int DEN_W      = ROOT_W + 2;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int DIV_STEPS  = DIVD_W;

    localparam logic [1:0] CASE_W = 2'd0;
    localparam logic [1:0] CASE_X = 2'd1;
    localparam logic [1:0] CASE_Y = 2'd2;
    localparam logic [1:0] CASE_Z = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [NUM_W-1:0]      num_t;

    // Sideband that rides along the pipeline beside the arithmetic.
    typedef struct packed {
        logic [1:0] sel;
        num_t       n0;
        num_t       n1;
        num_t       n2;
    } side_t;

    function automatic data_t sat_signed(input logic signed [DIVD_W:0] v);
        logic signed [DIVD_W:0] hi;
        logic signed [DIVD_W:0] lo;
        begin
            hi = (DIVD_W+1)'(2 ** (DATA_WIDTH-1) - 1);
            lo = -hi - (DIVD_W+1)'(1);
            if (v > hi)
                sat_signed = data_t'(hi);
            else if (v < lo)
                sat_signed = data_t'(lo);
            else
                sat_signed = data_t'(v);
        end
    endfunction
endpackage

FILE: src/rmq_front.sv
// Front stage: diagonal candidates, largest pick and off-diagonal numerators.
// Depends on rmq_pkg.
module rmq_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rmq_pkg::data_t        r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3,
    output logic                  out_valid,
    output logic [rmq_pkg::RAD_W-1:0] rad,
    output rmq_pkg::side_t        side
);
    typedef logic signed [rmq_pkg::CAND_W-1:0] cand_t;

    cand_t c0, c1, c2, c3, big;
    logic [1:0] sel;
    rmq_pkg::num_t a, b, c, d, e, f;
    logic valid_reg;
    logic [rmq_pkg::RAD_W-1:0] rad_reg;
    rmq_pkg::side_t side_reg, side_next;

    always_comb
    begin
        c0 = cand_t'(r1c1) + cand_t'(r2c2) + cand_t'(r3c3);
        c1 = cand_t'(r1c1) - cand_t'(r2c2) - cand_t'(r3c3);
        c2 = cand_t'(r2c2) - cand_t'(r1c1) - cand_t'(r3c3);
        c3 = cand_t'(r3c3) - cand_t'(r1c1) - cand_t'(r2c2);
        big = c0;
        sel = rmq_pkg::CASE_W;
        if (big < c1)
        begin
            big = c1;
            sel = rmq_pkg::CASE_X;
        end
        if (big < c2)
        begin
            big = c2;
            sel = rmq_pkg::CASE_Y;
        end
        if (big < c3)
        begin
            big = c3;
            sel = rmq_pkg::CASE_Z;
        end
        a = rmq_pkg::num_t'(r2c3) - rmq_pkg::num_t'(r3c2);
        b = rmq_pkg::num_t'(r3c1) - rmq_pkg::num_t'(r1c3);
        c = rmq_pkg::num_t'(r1c2) - rmq_pkg::num_t'(r2c1);
        d = rmq_pkg::num_t'(r1c2) + rmq_pkg::num_t'(r2c1);
        e = rmq_pkg::num_t'(r3c1) + rmq_pkg::num_t'(r1c3);
        f = rmq_pkg::num_t'(r2c3) + rmq_pkg::num_t'(r3c2);
        side_next.sel = sel;
        case (sel)
            rmq_pkg::CASE_W: begin side_next.n0 = a; side_next.n1 = b; side_next.n2 = c; end
            rmq_pkg::CASE_X: begin side_next.n0 = a; side_next.n1 = d; side_next.n2 = e; end
            rmq_pkg::CASE_Y: begin side_next.n0 = b; side_next.n1 = d; side_next.n2 = f; end
            default:         begin side_next.n0 = c; side_next.n1 = e; side_next.n2 = f; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // The largest candidate is never negative, so its low bits suffice.
    always_ff @(posedge clk)
    begin
        rad_reg  <= {rmq_pkg::RAD_W'(big[rmq_pkg::CAND_W-2:0])
                     + rmq_pkg::RAD_W'(2 ** rmq_pkg::FRAC_BITS)} << rmq_pkg::FRAC_BITS;
        side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;
endmodule

FILE: src/rmq_sqrt.sv
// Pipelined restoring square root, one result bit per stage.
// Depends on rmq_pkg; the sideband travels with each beat.
module rmq_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rmq_pkg::RAD_W-1:0]     rad,
    input  rmq_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [rmq_pkg::ROOT_W-1:0]    root,
    output rmq_pkg::side_t                out_side
);
    localparam int N  = rmq_pkg::SQ_STEPS;
    localparam int RW = rmq_pkg::ROOT_W + 2;
    localparam int VW = 2 * rmq_pkg::ROOT_W;

    logic [N:1]                       valid_reg;
    logic [VW-1:0]                    val_reg  [1:N];
    logic [RW-1:0]                    rem_reg  [1:N];
    logic [rmq_pkg::ROOT_W-1:0]       res_reg  [1:N];
    rmq_pkg::side_t                   side_reg [1:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[N-1:1], in_valid};
    end

    // Each stage brings down two radicand bits and tries 4*root+1.
    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic [VW-1:0]              val_cur;
        logic [RW-1:0]              rem_cur, rem_next, trial;
        logic [rmq_pkg::ROOT_W-1:0] res_cur;
        rmq_pkg::side_t             side_cur;

        if (s == 0)
        begin : g_head
            always_comb
            begin
                val_cur  = VW'(rad);
                rem_cur  = '0;
                res_cur  = '0;
                side_cur = in_side;
            end
        end
        else
        begin : g_body
            always_comb
            begin
                val_cur  = val_reg[s];
                rem_cur  = rem_reg[s];
                res_cur  = res_reg[s];
                side_cur = side_reg[s];
            end
        end

        always_comb
        begin
            rem_next = {rem_cur[RW-3:0], val_cur[VW-1:VW-2]};
            trial    = {res_cur, 2'b01};
        end
        always_ff @(posedge clk)
        begin
            val_reg[s+1]  <= val_cur << 2;
            side_reg[s+1] <= side_cur;
            if (rem_next >= trial)
            begin
                rem_reg[s+1] <= rem_next - trial;
                res_reg[s+1] <= {res_cur[rmq_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= rem_next;
                res_reg[s+1] <= {res_cur[rmq_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign root      = res_reg[N];
    assign out_side  = side_reg[N];
endmodule

FILE: src/rmq_div.sv
// Pipelined restoring divider for three quotients sharing one divisor.
// Depends on rmq_pkg; truncates toward zero and saturates.
module rmq_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [rmq_pkg::ROOT_W-1:0]    root,
    input  rmq_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [1:0]                    sel,
    output rmq_pkg::data_t                pick,
    output rmq_pkg::data_t                q0,
    output rmq_pkg::data_t                q1,
    output rmq_pkg::data_t                q2
);
    localparam int N  = rmq_pkg::DIV_STEPS;
    localparam int DW = rmq_pkg::DIVD_W;
    localparam int EW = rmq_pkg::DEN_W + 1;

    typedef struct packed {
        logic [DW-1:0] quo;
        logic [EW-1:0] rem;
        logic [DW-1:0] dvd;
        logic          neg;
    } lane_t;

    logic [N:1]                       valid_reg;
    logic [rmq_pkg::DEN_W-1:0]        den_reg  [1:N];
    logic [rmq_pkg::ROOT_W-2:0]       p_reg    [1:N];
    logic [1:0]                       sel_reg  [1:N];
    lane_t                            lane_reg [1:N][3];
    rmq_pkg::num_t                    nums [3];
    logic [rmq_pkg::ROOT_W-2:0]       p_in;
    logic [rmq_pkg::DEN_W-1:0]        den_in;
    lane_t                            lane_in [3];

    assign nums[0] = in_side.n0;
    assign nums[1] = in_side.n1;
    assign nums[2] = in_side.n2;
    assign p_in    = root[rmq_pkg::ROOT_W-1:1];
    assign den_in  = rmq_pkg::DEN_W'({p_in, 2'b00});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lane_in[k].neg = nums[k][rmq_pkg::NUM_W-1];
            lane_in[k].dvd = {(nums[k][rmq_pkg::NUM_W-1] ? -nums[k] : nums[k]),
                              rmq_pkg::FRAC_BITS'(0)};
            lane_in[k].rem = '0;
            lane_in[k].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[N-1:1], in_valid};
    end

    for (genvar s = 0; s < N; s++)
    begin : g_step
        logic [rmq_pkg::DEN_W-1:0]  den_cur;
        logic [rmq_pkg::ROOT_W-2:0] p_cur;
        logic [1:0]                 sel_cur;

        if (s == 0)
        begin : g_head
            always_comb
            begin
                den_cur = den_in;
                p_cur   = p_in;
                sel_cur = in_side.sel;
            end
        end
        else
        begin : g_body
            always_comb
            begin
                den_cur = den_reg[s];
                p_cur   = p_reg[s];
                sel_cur = sel_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[s+1] <= den_cur;
            p_reg[s+1]   <= p_cur;
            sel_reg[s+1] <= sel_cur;
        end
        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            lane_t         lane_cur;
            logic [EW-1:0] rem_next;
            if (s == 0)
            begin : g_head
                assign lane_cur = lane_in[k];
            end
            else
            begin : g_body
                assign lane_cur = lane_reg[s][k];
            end
            assign rem_next = {lane_cur.rem[EW-2:0], lane_cur.dvd[DW-1]};
            always_ff @(posedge clk)
            begin
                lane_reg[s+1][k].neg <= lane_cur.neg;
                lane_reg[s+1][k].dvd <= lane_cur.dvd << 1;
                if (rem_next >= EW'(den_cur))
                begin
                    lane_reg[s+1][k].rem <= rem_next - EW'(den_cur);
                    lane_reg[s+1][k].quo <= {lane_cur.quo[DW-2:0], 1'b1};
                end
                else
                begin
                    lane_reg[s+1][k].rem <= rem_next;
                    lane_reg[s+1][k].quo <= {lane_cur.quo[DW-2:0], 1'b0};
                end
            end
        end
    end

    // The divisor is at least 2.0, so quotients fit DIVD_W bits.
    logic signed [DW:0] sq [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = lane_reg[N][k].neg ? -$signed({1'b0, lane_reg[N][k].quo})
                                       :  $signed({1'b0, lane_reg[N][k].quo});
        end
    end

    assign out_valid = valid_reg[N];
    assign sel       = sel_reg[N];
    assign pick      = rmq_pkg::sat_signed((DW+1)'(p_reg[N]));
    assign q0        = rmq_pkg::sat_signed(sq[0]);
    assign q1        = rmq_pkg::sat_signed(sq[1]);
    assign q2        = rmq_pkg::sat_signed(sq[2]);
endmodule

FILE: src/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
// Usage: drive the nine signed Q1.14 entries with start high for one
// cycle per matrix. busy is always low, so a new beat is taken every
// cycle. Each beat yields one quaternion beat, shown for exactly one
// cycle with done high, together with largest_case.
// The pipeline has one front stage for candidates and selection, one
// stage per root bit of the square root, one stage per quotient bit of
// the three parallel dividers, and the output register. Throughput is
// one beat per cycle.
// Reset empties the pipeline; no done pulses follow until new beats.
// The receiver cannot stall, so results leave in order without holding.
module rotation_matrix_to_quaternion
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rmq_pkg::data_t r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3,
    output logic           done,
    output rmq_pkg::data_t quat_w,
    output rmq_pkg::data_t quat_x,
    output rmq_pkg::data_t quat_y,
    output rmq_pkg::data_t quat_z,
    output logic [1:0]     largest_case
);
    logic f_valid, s_valid, d_valid;
    logic [rmq_pkg::RAD_W-1:0]  rad;
    logic [rmq_pkg::ROOT_W-1:0] root;
    rmq_pkg::side_t f_side, s_side;
    logic [1:0] sel;
    rmq_pkg::data_t pick, q0, q1, q2;
    logic done_reg;
    rmq_pkg::data_t w_reg, x_reg, y_reg, z_reg;
    logic [1:0] case_reg;

    assign busy = 1'b0;

    rmq_front u_front (
        .clk, .rst_n, .in_valid(start & ~busy),
        .r1c1, .r1c2, .r1c3, .r2c1, .r2c2, .r2c3, .r3c1, .r3c2, .r3c3,
        .out_valid(f_valid), .rad, .side(f_side)
    );

    rmq_sqrt u_sqrt (
        .clk, .rst_n, .in_valid(f_valid), .rad, .in_side(f_side),
        .out_valid(s_valid), .root, .out_side(s_side)
    );

    rmq_div u_div (
        .clk, .rst_n, .in_valid(s_valid), .root, .in_side(s_side),
        .out_valid(d_valid), .sel, .pick, .q0, .q1, .q2
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        case_reg <= sel;
        case (sel)
            rmq_pkg::CASE_W: begin w_reg <= pick; x_reg <= q0; y_reg <= q1; z_reg <= q2; end
            rmq_pkg::CASE_X: begin x_reg <= pick; w_reg <= q0; y_reg <= q1; z_reg <= q2; end
            rmq_pkg::CASE_Y: begin y_reg <= pick; w_reg <= q0; x_reg <= q1; z_reg <= q2; end
            default:         begin z_reg <= pick; w_reg <= q0; x_reg <= q1; y_reg <= q2; end
        endcase
    end

    assign done         = done_reg;
    assign quat_w       = w_reg;
    assign quat_x       = x_reg;
    assign quat_y       = y_reg;
    assign quat_z       = z_reg;
    assign largest_case = case_reg;

    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n) d_valid |=> done)
        else $error("result beat lost");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n) !d_valid |=> !done)
        else $error("result beat invented");
endmodule

FILE: test/rotation_matrix_to_quaternion_tb.sv
// Testbench for the rotation matrix to quaternion converter.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; predicts each quaternion
// beat in software and checks every done beat against it in order.
module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    typedef struct {
        data_t      w;
        data_t      x;
        data_t      y;
        data_t      z;
        logic [1:0] pick;
    } quat_s;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    data_t r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3;
    logic  done;
    data_t quat_w, quat_x, quat_y, quat_z;
    logic [1:0] largest_case;

    quat_s pending_quats[$];
    int    error_count;
    int    cycle_count;
    bit    idle_allowed;

    rotation_matrix_to_quaternion dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .r1c1(r1c1), .r1c2(r1c2), .r1c3(r1c3),
        .r2c1(r2c1), .r2c2(r2c2), .r2c3(r2c3),
        .r3c1(r3c1), .r3c2(r3c2), .r3c3(r3c3),
        .done(done), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .largest_case(largest_case)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint root_floor(input longint v);
        longint r;
        longint b;
        begin
            r = 0;
            b = longint'(1) << 62;
            while (b > v)
                b = b >>> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >>> 1) + b;
                end
                else
                    r = r >>> 1;
                b = b >>> 2;
            end
            return r;
        end
    endfunction

    function automatic data_t clamp_q(input longint v);
        begin
            if (v > 32767)
                return data_t'(32767);
            if (v < -32768)
                return data_t'(-32768);
            return data_t'(v);
        end
    endfunction

    // Scaled quotient that truncates toward zero, then saturates.
    function automatic data_t scaled_quot(input longint num, input longint den);
        longint mag;
        longint q;
        begin
            if (den == 0)
                return '0;
            mag = (num < 0) ? -num : num;
            q = (mag <<< FRAC_BITS) / den;
            return clamp_q((num < 0) ? -q : q);
        end
    endfunction

    function automatic quat_s predict_quat(input data_t m[9]);
        longint a[9];
        longint cand[4];
        longint big;
        longint p;
        longint den;
        quat_s  q;
        int     i;
        begin
            for (i = 0; i < 9; i++)
                a[i] = m[i];
            cand[0] = a[0] + a[4] + a[8];
            cand[1] = a[0] - a[4] - a[8];
            cand[2] = a[4] - a[0] - a[8];
            cand[3] = a[8] - a[0] - a[4];
            big = cand[0];
            q.pick = CASE_W;
            for (i = 1; i < 4; i++)
                if (big < cand[i])
                begin
                    big = cand[i];
                    q.pick = 2'(i);
                end
            if (big < 0)
                big = 0;
            p = root_floor((big + (longint'(1) << FRAC_BITS)) <<< FRAC_BITS) >>> 1;
            den = p <<< 2;
            case (q.pick)
                CASE_W:
                begin
                    q.w = clamp_q(p);
                    q.x = scaled_quot(a[5] - a[7], den);
                    q.y = scaled_quot(a[6] - a[2], den);
                    q.z = scaled_quot(a[1] - a[3], den);
                end
                CASE_X:
                begin
                    q.x = clamp_q(p);
                    q.w = scaled_quot(a[5] - a[7], den);
                    q.y = scaled_quot(a[1] + a[3], den);
                    q.z = scaled_quot(a[6] + a[2], den);
                end
                CASE_Y:
                begin
                    q.y = clamp_q(p);
                    q.w = scaled_quot(a[6] - a[2], den);
                    q.x = scaled_quot(a[1] + a[3], den);
                    q.z = scaled_quot(a[5] + a[7], den);
                end
                default:
                begin
                    q.z = clamp_q(p);
                    q.w = scaled_quot(a[1] - a[3], den);
                    q.x = scaled_quot(a[6] + a[2], den);
                    q.y = scaled_quot(a[5] + a[7], den);
                end
            endcase
            return q;
        end
    endfunction

    // Sends one matrix beat, with a random idle gap first when allowed.
    task automatic send_matrix(input data_t m[9]);
        begin
            while (idle_allowed && $urandom_range(99) < 17)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start <= 1'b1;
            r1c1 <= m[0]; r1c2 <= m[1]; r1c3 <= m[2];
            r2c1 <= m[3]; r2c2 <= m[4]; r2c3 <= m[5];
            r3c1 <= m[6]; r3c2 <= m[7]; r3c3 <= m[8];
            @(posedge clk);
            while (busy)
                @(posedge clk);
            pending_quats.push_back(predict_quat(m));
        end
    endtask

    task automatic go_quiet();
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic data_t rand_entry();
        begin
            case ($urandom_range(5))
                0: return data_t'(-32768);
                1: return data_t'(32767);
                2: return data_t'($urandom_range(16384 + 2000, 16384 - 2000));
                3: return data_t'($urandom_range(2000) - 1000);
                default: return data_t'($urandom);
            endcase
        end
    endfunction

    task automatic test_directed();
        data_t m[9];
        int    i;
        begin
            // Identity, and half-turns about each axis, pick each case in turn.
            m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
            send_matrix(m);
            m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
            send_matrix(m);
            m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
            send_matrix(m);
            m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
            send_matrix(m);
            // All-zero diagonal: every candidate ties, so the trace wins.
            m = '{0, 100, -200, 300, 0, -400, 500, -600, 0};
            send_matrix(m);
            // The largest numerators drive quotients to both ends of range.
            m = '{0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0};
            send_matrix(m);
            m = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
            send_matrix(m);
            // Extreme diagonals give the largest radicand.
            m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
            send_matrix(m);
            m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
            send_matrix(m);
            m = '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768};
            send_matrix(m);
            m = '{-32768, 32767, -32768, 32767, -32768, -32768, 32767, 32767, 32767};
            send_matrix(m);
            m = '{-32768, 1, -1, 1, 32767, -1, -1, 1, -32768};
            send_matrix(m);
            for (i = 0; i < 6; i++)
            begin
                foreach (m[j])
                    m[j] = rand_entry();
                send_matrix(m);
            end
        end
    endtask

    task automatic test_random(input int count);
        data_t m[9];
        int    i;
        begin
            for (i = 0; i < count; i++)
            begin
                // A long burst in the middle runs with no gaps at all.
                idle_allowed = !(i >= count / 3 && i < count / 3 + 300);
                foreach (m[j])
                    m[j] = rand_entry();
                send_matrix(m);
            end
            idle_allowed = 1'b1;
        end
    endtask

    // Holds the sender off until the pipeline has drained.
    task automatic test_drain_pause();
        begin
            go_quiet();
            while (pending_quats.size() != 0)
                @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        quat_s exp_q;
        if (rst_n && done)
        begin
            if (pending_quats.size() == 0)
            begin
                $error("quaternion beat with no expectation waiting");
                error_count++;
            end
            else
            begin
                exp_q = pending_quats.pop_front();
                if (quat_w !== exp_q.w)
                begin
                    $error("quat_w expected %0d actual %0d", exp_q.w, quat_w);
                    error_count++;
                end
                if (quat_x !== exp_q.x)
                begin
                    $error("quat_x expected %0d actual %0d", exp_q.x, quat_x);
                    error_count++;
                end
                if (quat_y !== exp_q.y)
                begin
                    $error("quat_y expected %0d actual %0d", exp_q.y, quat_y);
                    error_count++;
                end
                if (quat_z !== exp_q.z)
                begin
                    $error("quat_z expected %0d actual %0d", exp_q.z, quat_z);
                    error_count++;
                end
                if (largest_case !== exp_q.pick)
                begin
                    $error("largest_case expected %0d actual %0d", exp_q.pick,
                           largest_case);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        error_count  = 0;
        cycle_count  = 0;
        idle_allowed = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        {r1c1, r1c2, r1c3, r2c1, r2c2, r2c3, r3c1, r3c2, r3c3} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_drain_pause();
        test_random(1400);
        go_quiet();
        while (pending_quats.size() != 0)
            @(posedge clk);
        wait_cycles = 0;
        while (wait_cycles < 60)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
src/rmq_pkg.sv
src/rmq_front.sv
src/rmq_sqrt.sv
src/rmq_div.sv
src/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_tb.sv
